// ----- sv/srle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_pkg
// Shared types, codes and helpers for the S-record line encoder.
// ----------------------------------------------------------------------------
package srle_pkg;

   localparam int MAX_DATA_BYTES_DEFAULT = 250;
   localparam int QUEUE_DEPTH            = 4;

   typedef enum logic [2:0] {
      MODE_HEADER = 3'd0,
      MODE_START  = 3'd1,
      MODE_DATA   = 3'd2,
      MODE_EXEC   = 3'd3
   } mode_type;

   localparam logic [7:0] CSR_DATA_ONLY = 8'd0;
   localparam logic [7:0] CSR_MIN_ADDR  = 8'd1;

   localparam logic [6:0] CHAR_S  = 7'h53;
   localparam logic [6:0] CHAR_NL = 7'h0A;

   localparam logic [7:0]  HDR_LEN   = 8'h06;
   localparam logic [23:0] HDR_TEXT  = 24'h484452;
   localparam logic [7:0]  HDR_CHECK = ~8'(HDR_LEN + 8'h48 + 8'h44 + 8'h52);

   // one line segment for the character sequencer; bytes are sent from the top
   typedef struct packed {
      logic        prefix;
      logic [3:0]  tag;
      logic [2:0]  nbytes;
      logic [47:0] bytes;
      logic        tail;
      logic [7:0]  check;
      logic        last;
   } job_type;

   function automatic logic [6:0] hex_char(input logic [3:0] d);
      return (d < 4'd10) ? (7'h30 + {3'b000, d}) : (7'h37 + {3'b000, d});
   endfunction

endpackage

// ----- sv/srle_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_fifo
// Short job queue between the front end and the character sequencer.
// ----------------------------------------------------------------------------
module srle_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  srle_pkg::job_type push_job,
   output logic             push_ready,
   output logic             pop_valid,
   output srle_pkg::job_type pop_job,
   input  logic             pop
);
   import srle_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   job_type       mem [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- sv/srle_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_front
// Accepts items, keeps record state and settings, and queues line jobs.
// ----------------------------------------------------------------------------
module srle_front #(
   parameter int MAX_DATA_BYTES = srle_pkg::MAX_DATA_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_mode,
   input  logic [31:0]      req_address,
   input  logic [7:0]       req_record_length,
   input  logic [7:0]       req_data_byte,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [2:0]       csr_wdata,
   output logic             push_valid,
   output srle_pkg::job_type push_job,
   input  logic             push_ready
);
   import srle_pkg::*;

   localparam logic [7:0] MAX_LEN = 8'(MAX_DATA_BYTES);

   logic        data_only_ff, data_only_in;
   logic [2:0]  min_addr_ff, min_addr_in;
   logic [15:0] counter_ff, counter_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  left_ff, left_in;
   logic        open_ff, open_in;
   logic        pend_ff, pend_in;
   job_type     pend_job_ff, pend_job_in;

   logic        accept;
   logic        emit;
   logic        two_jobs;
   job_type     job_a;
   job_type     job_b;
   logic [2:0]  width;
   logic [7:0]  len_sat;
   logic [7:0]  len_byte;
   logic [7:0]  head_sum;
   logic [7:0]  data_sum;
   logic [7:0]  cnt_sum;

   function automatic logic [47:0] pack_bytes(input logic [7:0] first,
                                              input logic [31:0] a,
                                              input logic [2:0] w);
      case (w)
         3'd2:    return {first, a[15:0], 24'h0};
         3'd3:    return {first, a[23:0], 16'h0};
         default: return {first, a, 8'h0};
      endcase
   endfunction

   function automatic logic [7:0] sum_bytes(input logic [7:0] first,
                                            input logic [31:0] a,
                                            input logic [2:0] w);
      logic [7:0] s;
      s = first + a[7:0] + a[15:8];
      if (w != 3'd2) s = s + a[23:16];
      if (w == 3'd4) s = s + a[31:24];
      return s;
   endfunction

   assign csr_ready = 1'b1;
   assign req_stall = pend_ff || !push_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (req_address[31:16] == 16'h0 && min_addr_ff <= 3'd2) begin
         width = 3'd2;
      end else if (req_address[31:24] == 8'h0 && min_addr_ff <= 3'd3) begin
         width = 3'd3;
      end else begin
         width = 3'd4;
      end
   end

   assign len_sat  = (req_record_length > MAX_LEN) ? MAX_LEN : req_record_length;
   assign len_byte = 8'(width) + len_sat + 8'd1;
   assign head_sum = sum_bytes(len_byte, req_address, width);
   assign data_sum = sum_ff + req_data_byte;
   assign cnt_sum  = 8'd3 + counter_ff[15:8] + counter_ff[7:0];

   always_comb begin
      emit       = 1'b0;
      two_jobs   = 1'b0;
      counter_in = counter_ff;
      sum_in     = sum_ff;
      left_in    = left_ff;
      open_in    = open_ff;
      job_a      = '{prefix: 1'b1, tag: 4'd0, nbytes: 3'd1, bytes: '0,
                     tail: 1'b1, check: 8'h0, last: 1'b1};
      job_b      = job_a;
      if (accept) begin
         case (req_mode)
            MODE_HEADER: begin
               if (!data_only_ff) begin
                  emit         = 1'b1;
                  open_in      = 1'b0;
                  left_in      = 8'd0;
                  job_a.tag    = 4'd0;
                  job_a.nbytes = 3'd6;
                  job_a.bytes  = {HDR_LEN, 16'h0, HDR_TEXT};
                  job_a.check  = HDR_CHECK;
               end
            end
            MODE_START: begin
               emit         = 1'b1;
               job_a.tag    = {1'b0, width - 3'd1};
               job_a.nbytes = width + 3'd1;
               job_a.bytes  = pack_bytes(len_byte, req_address, width);
               job_a.tail   = (len_sat == 8'd0);
               job_a.check  = ~head_sum;
               sum_in       = head_sum;
               counter_in   = counter_ff + 16'd1;
               open_in      = (len_sat != 8'd0);
               left_in      = len_sat;
            end
            MODE_DATA: begin
               if (open_ff && left_ff != 8'd0) begin
                  emit         = 1'b1;
                  job_a.prefix = 1'b0;
                  job_a.bytes  = {req_data_byte, 40'h0};
                  job_a.tail   = (left_ff == 8'd1);
                  job_a.check  = ~data_sum;
                  sum_in       = data_sum;
                  left_in      = left_ff - 8'd1;
                  open_in      = (left_ff != 8'd1);
               end
            end
            MODE_EXEC: begin
               if (!data_only_ff) begin
                  emit         = 1'b1;
                  two_jobs     = 1'b1;
                  open_in      = 1'b0;
                  left_in      = 8'd0;
                  job_a.tag    = 4'd5;
                  job_a.nbytes = 3'd3;
                  job_a.bytes  = {8'h03, counter_ff, 24'h0};
                  job_a.check  = ~cnt_sum;
                  job_a.last   = 1'b0;
                  job_b.tag    = 4'd11 - {1'b0, width};
                  job_b.nbytes = width + 3'd1;
                  job_b.bytes  = pack_bytes(8'(width) + 8'd1, req_address, width);
                  job_b.check  = ~sum_bytes(8'(width) + 8'd1, req_address, width);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign push_valid = pend_ff || emit;
   assign push_job   = pend_ff ? pend_job_ff : job_a;

   always_comb begin
      pend_in     = pend_ff;
      pend_job_in = pend_job_ff;
      if (two_jobs) begin
         pend_in     = 1'b1;
         pend_job_in = job_b;
      end else if (pend_ff && push_ready) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      data_only_in = data_only_ff;
      min_addr_in  = min_addr_ff;
      if (csr_valid) begin
         if (csr_index == CSR_DATA_ONLY) data_only_in = csr_wdata[0];
         else if (csr_index == CSR_MIN_ADDR) min_addr_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_only_ff <= 1'b0;
         min_addr_ff  <= 3'd2;
         counter_ff   <= '0;
         sum_ff       <= '0;
         left_ff      <= '0;
         open_ff      <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         data_only_ff <= data_only_in;
         min_addr_ff  <= min_addr_in;
         counter_ff   <= counter_in;
         sum_ff       <= sum_in;
         left_ff      <= left_in;
         open_ff      <= open_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_job_ff <= pend_job_in;
   end

endmodule

// ----- sv/srle_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_back
// Character sequencer: queued jobs to one ASCII char a cycle unless stalled.
// ----------------------------------------------------------------------------
module srle_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  srle_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [6:0]       rsp_text_char,
   output logic             rsp_last_of_run
);
   import srle_pkg::*;

   typedef enum logic [7:0] {
      PH_IDLE = 8'b0000_0001,
      PH_S    = 8'b0000_0010,
      PH_TAG  = 8'b0000_0100,
      PH_HI   = 8'b0000_1000,
      PH_LO   = 8'b0001_0000,
      PH_CKHI = 8'b0010_0000,
      PH_CKLO = 8'b0100_0000,
      PH_NL   = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in, phase_next;
   logic [3:0]  tag_ff, tag_in;
   logic [47:0] shift_ff, shift_in;
   logic [2:0]  left_ff, left_in;
   logic        tail_ff, tail_in;
   logic [7:0]  check_ff, check_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  char_ff, char_in;
   logic        rlast_ff, rlast_in;

   logic        adv;
   logic        final_char;
   logic [6:0]  cur_char;
   logic        load;

   assign adv = (phase_ff != PH_IDLE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_next = PH_IDLE;
      final_char = 1'b0;
      cur_char   = CHAR_NL;
      case (phase_ff)
         PH_S: begin
            cur_char   = CHAR_S;
            phase_next = PH_TAG;
         end
         PH_TAG: begin
            cur_char   = hex_char(tag_ff);
            phase_next = PH_HI;
         end
         PH_HI: begin
            cur_char   = hex_char(shift_ff[47:44]);
            phase_next = PH_LO;
         end
         PH_LO: begin
            cur_char = hex_char(shift_ff[43:40]);
            if (left_ff != 3'd1) begin
               phase_next = PH_HI;
            end else if (tail_ff) begin
               phase_next = PH_CKHI;
            end else begin
               final_char = 1'b1;
            end
         end
         PH_CKHI: begin
            cur_char   = hex_char(check_ff[7:4]);
            phase_next = PH_CKLO;
         end
         PH_CKLO: begin
            cur_char   = hex_char(check_ff[3:0]);
            phase_next = PH_NL;
         end
         PH_NL: begin
            final_char = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign load    = job_valid && (phase_ff == PH_IDLE || (adv && final_char));
   assign job_pop = load;

   always_comb begin
      phase_in = phase_ff;
      tag_in   = tag_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      tail_in  = tail_ff;
      check_in = check_ff;
      last_in  = last_ff;
      if (load) begin
         phase_in = job.prefix ? PH_S : PH_HI;
         tag_in   = job.tag;
         shift_in = job.bytes;
         left_in  = job.nbytes;
         tail_in  = job.tail;
         check_in = job.check;
         last_in  = job.last;
      end else if (adv) begin
         phase_in = phase_next;
         if (phase_ff == PH_LO) begin
            shift_in = {shift_ff[39:0], 8'h0};
            left_in  = left_ff - 3'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in      = char_ff;
      rlast_in     = rlast_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
         char_in      = cur_char;
         rlast_in     = final_char && last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      shift_ff <= shift_in;
      left_ff  <= left_in;
      tail_ff  <= tail_in;
      check_ff <= check_in;
      last_ff  <= last_in;
      char_ff  <= char_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_char   = char_ff;
   assign rsp_last_of_run = rlast_ff;

endmodule

// ----- sv/s_record_line_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s_record_line_encoder
// Motorola S-record text encoder, one ASCII character per rsp transfer.
//
// req_* carries one item per transfer (valid high, stall low): header, data
// record start, data byte or start address. rsp_* returns the characters in
// order; rsp_last_of_run marks the final character an item causes. csr_*
// writes data_only (index 0) and min_address_bytes (index 1); always ready.
// The front end takes one item a cycle, while req_stall is low, into a
// four-entry job queue; the character sequencer behind it sends one
// character a cycle while rsp_stall is low, so a data byte yields two
// characters (five when it closes the line) and a record start 8 to 15.
// A start-address item holds req_stall until its second line is queued.
// req_stall rises when the queue fills; rsp_stall holds the output
// register and backs up the queue. Synchronous reset empties the queue,
// clears record state and restores the register defaults.
// ----------------------------------------------------------------------------
module s_record_line_encoder #(
   parameter int MAX_DATA_BYTES = srle_pkg::MAX_DATA_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_address,
   input  logic [7:0]  req_record_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_text_char,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [2:0]  csr_wdata
);
   import srle_pkg::*;

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop;
   job_type pop_job;

   srle_front #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_address      (req_address),
      .req_record_length(req_record_length),
      .req_data_byte    (req_data_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .push_valid       (push_valid),
      .push_job         (push_job),
      .push_ready       (push_ready)
   );

   srle_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_job  (push_job),
      .push_ready(push_ready),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop       (pop)
   );

   srle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (pop_valid),
      .job            (pop_job),
      .job_pop        (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_char  (rsp_text_char),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule
